// File: src/ffla_pkg.sv
// Package for the first-fit lifetime allocator.
// Holds the controller state type, status codes and the control/status structs.
package ffla_pkg;

   localparam int VAL_W = 36;

   localparam logic [1:0] ST_PLACED   = 2'd0;
   localparam logic [1:0] ST_DEFERRED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_RD, S_CHK, S_RND, S_FIN, S_PST, S_PRND, S_OUT
   } ffla_state_type;

   typedef struct packed {
      logic load;
      logic pass;
      logic rd;
      logic adv;
      logic rnd_start;
      logic rnd_pool;
      logic take_cand;
      logic take_pool;
      logic set_zero;
      logic set_full;
      logic fin;
      logic out_load;
   } ffla_cmd_type;

   typedef struct packed {
      logic size_zero;
      logic full;
      logic empty;
      logic hit;
      logic last;
      logic changed;
      logic rnd_done;
   } ffla_stat_type;

endpackage

// File: src/ffla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/ffla_round.sv
// Round-up to a multiple of ALIGN_BYTES; remainder found four bits per cycle
// by compare and subtract against constant multiples. Depends on ffla_pkg.
module ffla_round #(
   parameter int ALIGN_BYTES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ffla_pkg::VAL_W-1:0] value,
   output logic                      done,
   output logic [ffla_pkg::VAL_W-1:0] result
);
   import ffla_pkg::*;

   localparam int RW = $clog2(ALIGN_BYTES) + 1;
   localparam int XW = RW + 4;
   localparam int ND = (VAL_W + 3) / 4;
   localparam int SW = ND * 4;
   localparam int NW = $clog2(ND + 1);
   localparam logic [RW-1:0] A_R = RW'(ALIGN_BYTES);

   logic [VAL_W-1:0] v_ff;
   logic [SW-1:0]    sh_ff, sh_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [XW-1:0]    r4, r_sub;
   logic [RW-1:0]    pad;

   always_comb begin
      r4    = {r_ff, sh_ff[SW-1 -: 4]};
      r_sub = r4;
      for (int k = 1; k < 16; k++) begin
         if (r4 >= XW'(k * ALIGN_BYTES)) begin
            r_sub = r4 - XW'(k * ALIGN_BYTES);
         end
      end
      r_in   = r_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      if (start) begin
         r_in   = '0;
         sh_in  = SW'(value);
         cnt_in = NW'(ND);
      end else if (cnt_ff != '0) begin
         r_in   = r_sub[RW-1:0];
         sh_in  = {sh_ff[SW-5:0], 4'b0000};
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      r_ff  <= r_in;
      sh_ff <= sh_in;
      if (start) begin
         v_ff <= value;
      end
   end

   assign pad    = (r_ff == '0) ? '0 : (A_R - r_ff);
   assign done   = (cnt_ff == '0);
   assign result = v_ff + VAL_W'(pad);
endmodule

// File: src/ffla_datapath.sv
// Datapath: request registers, region table RAM, candidate, overlap test, results.
// Depends on ffla_pkg, ffla_ram and ffla_round.
module ffla_datapath #(
   parameter int MAX_REGIONS = 64,
   parameter int ALIGN_BYTES = 16,
   parameter int ADDR_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffla_pkg::ffla_cmd_type  cmd,
   output ffla_pkg::ffla_stat_type stat,
   input  logic                    req_restart,
   input  logic [31:0]             req_request_size,
   input  logic [15:0]             req_birth_step,
   input  logic [15:0]             req_death_step,
   output logic [31:0]             rsp_placed_offset,
   output logic [33:0]             rsp_pool_bytes,
   output logic [1:0]              rsp_status
);
   import ffla_pkg::*;

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int DW = 80;
   localparam logic [VAL_W-1:0] LIMIT =
      (ADDR_BITS >= 32) ? (VAL_W'(1) << 32) : (VAL_W'(1) << ADDR_BITS);

   logic [31:0]      size_ff;
   logic [15:0]      birth_ff, death_ff;
   logic [VAL_W-1:0] cand_ff, pool_ff;
   logic [IW-1:0]    idx_ff;
   logic [CW-1:0]    count_ff;
   logic [32:0]      highest_ff;
   logic             changed_ff;
   logic [31:0]      offset_ff, out_offset_ff;
   logic [1:0]       status_ff, out_status_ff;
   logic [33:0]      out_pool_ff;

   logic [DW-1:0]    rd_data;
   logic [31:0]      rd_start, rd_len;
   logic [15:0]      rd_death;
   logic [VAL_W-1:0] hi, cand_end, rnd_val, rnd_res;
   logic             rnd_done, ovf, wr_en;

   assign rd_start = rd_data[79:48];
   assign rd_len   = rd_data[47:16];
   assign rd_death = rd_data[15:0];
   assign hi       = VAL_W'({1'b0, rd_start} + {1'b0, rd_len});
   assign cand_end = cand_ff + VAL_W'(size_ff);
   assign ovf      = cand_end > LIMIT;
   assign wr_en    = cmd.fin && !ovf;
   assign rnd_val  = cmd.rnd_pool ? VAL_W'(highest_ff) : hi;

   ffla_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({cand_ff[31:0], size_ff, death_ff}),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   ffla_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.rnd_start),
      .value  (rnd_val),
      .done   (rnd_done),
      .result (rnd_res)
   );

   always_comb begin
      stat.size_zero = (size_ff == '0);
      stat.full      = (count_ff >= CW'(MAX_REGIONS));
      stat.empty     = (count_ff == '0);
      stat.hit       = (rd_death >= birth_ff) && (VAL_W'(rd_start) < cand_end)
                       && (hi > cand_ff);
      stat.last      = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.changed   = changed_ff;
      stat.rnd_done  = rnd_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         highest_ff <= '0;
      end else if (cmd.load && req_restart) begin
         count_ff   <= '0;
         highest_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CW'(1);
         if (cand_end > VAL_W'(highest_ff)) begin
            highest_ff <= cand_end[32:0];
         end
      end

      if (cmd.load) begin
         size_ff  <= req_request_size;
         birth_ff <= req_birth_step;
         death_ff <= req_death_step;
         cand_ff  <= '0;
      end else if (cmd.take_cand) begin
         cand_ff <= rnd_res;
      end

      if (cmd.pass) begin
         idx_ff     <= '0;
         changed_ff <= 1'b0;
      end else begin
         if (cmd.adv) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.take_cand) begin
            changed_ff <= 1'b1;
         end
      end

      if (cmd.set_zero) begin
         status_ff <= ST_DEFERRED;
         offset_ff <= '1;
      end else if (cmd.set_full) begin
         status_ff <= ST_FULL;
         offset_ff <= '0;
      end else if (cmd.fin) begin
         status_ff <= ovf ? ST_OVERFLOW : ST_PLACED;
         offset_ff <= ovf ? '0 : cand_ff[31:0];
      end

      if (cmd.take_pool) begin
         pool_ff <= rnd_res;
      end

      if (cmd.out_load) begin
         out_offset_ff <= offset_ff;
         out_status_ff <= status_ff;
         out_pool_ff   <= pool_ff[33:0];
      end
   end

   assign rsp_placed_offset = out_offset_ff;
   assign rsp_pool_bytes    = out_pool_ff;
   assign rsp_status        = out_status_ff;
endmodule

// File: src/ffla_ctrl.sv
// Controller state machine: scan passes, rounding, commit and output handshake.
// Depends on ffla_pkg.
module ffla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ffla_pkg::ffla_stat_type stat,
   output ffla_pkg::ffla_cmd_type  cmd
);
   import ffla_pkg::*;

   ffla_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (stat.size_zero) begin
               cmd.set_zero = 1'b1;
               state_in     = S_PST;
            end else if (stat.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_PST;
            end else if (stat.empty) begin
               state_in = S_FIN;
            end else begin
               cmd.pass = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (stat.hit) begin
               cmd.rnd_start = 1'b1;
               state_in      = S_RND;
            end else if (!stat.last) begin
               cmd.adv  = 1'b1;
               state_in = S_RD;
            end else if (stat.changed) begin
               cmd.pass = 1'b1;
               state_in = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RND: begin
            if (stat.rnd_done) begin
               cmd.take_cand = 1'b1;
               if (stat.last) begin
                  cmd.pass = 1'b1;
               end else begin
                  cmd.adv = 1'b1;
               end
               state_in = S_RD;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_PST;
         end
         S_PST: begin
            cmd.rnd_start = 1'b1;
            cmd.rnd_pool  = 1'b1;
            state_in      = S_PRND;
         end
         S_PRND: begin
            if (stat.rnd_done) begin
               cmd.take_pool = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: src/first_fit_lifetime_allocator.sv
// Top level of the first-fit lifetime allocator.
// Depends on ffla_pkg, ffla_ctrl and ffla_datapath.
//
//   channel | ports                                              | dir
//   req     | req_valid/req_ready, restart, size, birth, death   | in
//   rsp     | rsp_valid/rsp_ready, placed_offset, pool_bytes, st | out
//
// One request at a time. The scan reads the stored regions one at a time from
// the table RAM and repeats passes until the candidate settles; each push and
// the final pool size use a four-bits-per-cycle round-up. Reset is synchronous;
// the table needs no clearing. A request may be taken while the previous word
// still waits on rsp.
module first_fit_lifetime_allocator #(
   parameter int MAX_REGIONS = 64,
   parameter int ALIGN_BYTES = 16,
   parameter int ADDR_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   input  logic [31:0] req_request_size,
   input  logic [15:0] req_birth_step,
   input  logic [15:0] req_death_step,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_placed_offset,
   output logic [33:0] rsp_pool_bytes,
   output logic [1:0]  rsp_status
);
   import ffla_pkg::*;

   ffla_cmd_type  cmd;
   ffla_stat_type stat;

   ffla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffla_datapath #(
      .MAX_REGIONS (MAX_REGIONS),
      .ALIGN_BYTES (ALIGN_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_restart       (req_restart),
      .req_request_size  (req_request_size),
      .req_birth_step    (req_birth_step),
      .req_death_step    (req_death_step),
      .rsp_placed_offset (rsp_placed_offset),
      .rsp_pool_bytes    (rsp_pool_bytes),
      .rsp_status        (rsp_status)
   );
endmodule
